// ----- src/spkt_pkg.sv -----
// Shared types, widths and codes of the sorted pair-key table.
package spkt_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int KEY_W        = 16;
    localparam int MEAS_W       = 32;
    localparam int MODE_W       = 3;
    localparam int STATUS_W     = 2;

    localparam logic [MODE_W-1:0] MODE_INS_KEEP = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INS_UPD  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LOOKUP   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REMOVE   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FIND_MAX = 3'd4;
    localparam logic [MODE_W-1:0] MODE_FIND_MIN = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic signed [KEY_W-1:0]  key_x;
        logic signed [KEY_W-1:0]  key_y;
        logic signed [MEAS_W-1:0] measure;
    } t_entry;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_CMP,
        CELL_INS,
        CELL_UPD,
        CELL_REM,
        CELL_ROT
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_entry   data;
    } t_cell_cmd;

endpackage

// ----- src/spkt_cell.sv -----
// One table cell: holds one entry, compares it with the broadcast key, shifts to neighbors.
module spkt_cell (
    input  logic               i_clk,
    input  spkt_pkg::t_cell_cmd i_cmd,
    input  logic               i_held,
    input  logic               i_last,
    input  logic               i_prev_lt,
    input  spkt_pkg::t_entry   i_prev,
    input  spkt_pkg::t_entry   i_next,
    input  spkt_pkg::t_entry   i_head,
    output spkt_pkg::t_entry   o_entry,
    output logic               o_lt,
    output logic               o_eq
);

    spkt_pkg::t_entry r_entry;
    spkt_pkg::t_entry n_entry;
    logic             r_lt;
    logic             n_lt;
    logic             r_eq;
    logic             n_eq;
    logic             x_eq;
    logic             key_eq;
    logic             key_lt;

    always_comb begin
        x_eq   = (r_entry.key_x == i_cmd.data.key_x);
        key_eq = x_eq && (r_entry.key_y == i_cmd.data.key_y);
        key_lt = ($signed(r_entry.key_x) < $signed(i_cmd.data.key_x)) ||
                 (x_eq && ($signed(r_entry.key_y) < $signed(i_cmd.data.key_y)));

        n_entry = r_entry;
        n_lt    = r_lt;
        n_eq    = r_eq;
        case (i_cmd.op)
            spkt_pkg::CELL_CMP: begin
                n_lt = i_held && key_lt;
                n_eq = i_held && key_eq;
            end
            spkt_pkg::CELL_INS: begin
                // cells at or after the insert point move up; the first one takes the new item
                if (!r_lt) begin
                    n_entry = i_prev_lt ? i_cmd.data : i_prev;
                end
            end
            spkt_pkg::CELL_UPD: begin
                if (r_eq) begin
                    n_entry.measure = i_cmd.data.measure;
                end
            end
            spkt_pkg::CELL_REM: begin
                if (!r_lt) begin
                    n_entry = i_next;
                end
            end
            spkt_pkg::CELL_ROT: begin
                n_entry = i_last ? i_head : i_next;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_lt    <= n_lt;
        r_eq    <= n_eq;
    end

    assign o_entry = r_entry;
    assign o_lt    = r_lt;
    assign o_eq    = r_eq;

endmodule

// ----- src/spkt_scan.sv -----
// Running max/min tracker fed from the head cell while the table rotates.
module spkt_scan (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic             i_first,
    input  logic             i_find_max,
    input  spkt_pkg::t_entry i_entry,
    output spkt_pkg::t_entry o_best
);

    spkt_pkg::t_entry r_best;
    logic             better;

    // strict compare: on a tie the earlier entry stays
    always_comb begin
        if (i_find_max) begin
            better = $signed(i_entry.measure) > $signed(r_best.measure);
        end else begin
            better = $signed(i_entry.measure) < $signed(r_best.measure);
        end
        o_best = (i_first || better) ? i_entry : r_best;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_best <= o_best;
        end
    end

endmodule

// ----- src/sorted_pair_key_table.sv -----
// Top level of the sorted pair-key table: cell chain, control sequencer and result register.
//
// Sorted table of up to CAPACITY entries, each a signed (key_x, key_y) pair with a signed
// measure, kept in ascending key order (key_x first, then key_y) in a chain of cells, one
// entry per cell. Insert, lookup and remove step through S_CMP, S_SEL, S_APPLY and S_DONE,
// and o_stall holds off the next item until S_IDLE: all cells compare their key with the
// item's key at once in S_CMP, the hit entry is picked out in S_SEL, and in S_APPLY every
// cell shifts toward or away from its neighbor at once to open or close the gap. Find max
// and find min rotate the held entries past the head cell, one entry a cycle, and an empty
// table skips the rotation with an empty status. Modes six and seven return an empty result
// with the count. The result sits in an output register, so the next item is accepted while
// a result still waits on i_stall. The table contents need no clearing after reset: only
// the held count, the state and the output valid flag are cleared.
module sorted_pair_key_table #(
    parameter int CAPACITY = spkt_pkg::CAPACITY_DEF,
    localparam int CW      = $clog2(CAPACITY + 1)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [spkt_pkg::MODE_W-1:0]         i_mode,
    input  logic signed [spkt_pkg::KEY_W-1:0]   i_key_x,
    input  logic signed [spkt_pkg::KEY_W-1:0]   i_key_y,
    input  logic signed [spkt_pkg::MEAS_W-1:0]  i_measure_in,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_found,
    output logic signed [spkt_pkg::KEY_W-1:0]   o_key_x_out,
    output logic signed [spkt_pkg::KEY_W-1:0]   o_key_y_out,
    output logic signed [spkt_pkg::MEAS_W-1:0]  o_measure_out,
    output logic [CW-1:0]                       o_entry_count,
    output logic [spkt_pkg::STATUS_W-1:0]       o_status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_SEL,
        S_APPLY,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                          r_state, n_state;
    logic [spkt_pkg::MODE_W-1:0]     r_mode, n_mode;
    spkt_pkg::t_entry                r_in, n_in;
    logic [CW-1:0]                   r_count, n_count;
    logic                            r_hit, n_hit;
    spkt_pkg::t_entry                r_sel, n_sel;
    logic [CW-1:0]                   r_scan_cnt, n_scan_cnt;
    logic                            r_res_found, n_res_found;
    spkt_pkg::t_entry                r_res, n_res;
    logic [spkt_pkg::STATUS_W-1:0]   r_res_status, n_res_status;
    logic                            r_out_valid, n_out_valid;
    logic                            r_out_found, n_out_found;
    spkt_pkg::t_entry                r_out, n_out;
    logic [CW-1:0]                   r_out_count, n_out_count;
    logic [spkt_pkg::STATUS_W-1:0]   r_out_status, n_out_status;

    spkt_pkg::t_cell_cmd             cell_cmd;
    spkt_pkg::t_entry                entries [CAPACITY];
    logic [CAPACITY-1:0]             lt_v;
    logic [CAPACITY-1:0]             eq_v;
    spkt_pkg::t_entry                sel_comb;
    spkt_pkg::t_entry                scan_best;
    logic                            accept;
    logic                            full;
    logic                            scan_last;

    assign accept    = i_valid && (r_state == S_IDLE);
    assign o_stall   = (r_state != S_IDLE);
    assign full      = (r_count == CW'(CAPACITY));
    assign scan_last = (r_scan_cnt == r_count - CW'(1));

    // ---------------------------------------------------------------- cell chain
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        spkt_pkg::t_entry prev_e;
        spkt_pkg::t_entry next_e;
        logic             prev_lt;

        if (g == 0) begin : g_first
            assign prev_e  = entries[0];
            assign prev_lt = 1'b1;
        end else begin : g_mid
            assign prev_e  = entries[g-1];
            assign prev_lt = lt_v[g-1];
        end

        if (g == CAPACITY - 1) begin : g_end
            assign next_e = entries[g];
        end else begin : g_body
            assign next_e = entries[g+1];
        end

        spkt_cell u_cell (
            .i_clk     (i_clk),
            .i_cmd     (cell_cmd),
            .i_held    (CW'(g) < r_count),
            .i_last    (CW'(g) == r_count - CW'(1)),
            .i_prev_lt (prev_lt),
            .i_prev    (prev_e),
            .i_next    (next_e),
            .i_head    (entries[0]),
            .o_entry   (entries[g]),
            .o_lt      (lt_v[g]),
            .o_eq      (eq_v[g])
        );
    end

    // keys are unique, so at most one cell flags a hit: a one-hot AND-OR picks it out
    always_comb begin
        sel_comb = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (eq_v[i]) begin
                sel_comb = spkt_pkg::t_entry'(sel_comb | entries[i]);
            end
        end
    end

    spkt_scan u_scan (
        .i_clk      (i_clk),
        .i_en       (r_state == S_SCAN),
        .i_first    (r_scan_cnt == '0),
        .i_find_max (r_mode == spkt_pkg::MODE_FIND_MAX),
        .i_entry    (entries[0]),
        .o_best     (scan_best)
    );

    // ---------------------------------------------------------------- cell command
    always_comb begin
        cell_cmd.data = r_in;
        cell_cmd.op   = spkt_pkg::CELL_HOLD;
        case (r_state)
            S_CMP: begin
                cell_cmd.op = spkt_pkg::CELL_CMP;
            end
            S_APPLY: begin
                case (r_mode)
                    spkt_pkg::MODE_INS_KEEP: begin
                        if (!r_hit && !full) begin
                            cell_cmd.op = spkt_pkg::CELL_INS;
                        end
                    end
                    spkt_pkg::MODE_INS_UPD: begin
                        if (r_hit) begin
                            cell_cmd.op = spkt_pkg::CELL_UPD;
                        end else if (!full) begin
                            cell_cmd.op = spkt_pkg::CELL_INS;
                        end
                    end
                    spkt_pkg::MODE_REMOVE: begin
                        if (r_hit) begin
                            cell_cmd.op = spkt_pkg::CELL_REM;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_SCAN: begin
                cell_cmd.op = spkt_pkg::CELL_ROT;
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_in         = r_in;
        n_count      = r_count;
        n_hit        = r_hit;
        n_sel        = r_sel;
        n_scan_cnt   = r_scan_cnt;
        n_res_found  = r_res_found;
        n_res        = r_res;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_out_found  = r_out_found;
        n_out        = r_out;
        n_out_count  = r_out_count;
        n_out_status = r_out_status;

        // drop the result once the downstream side takes it
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_mode          = i_mode;
                    n_in.key_x      = i_key_x;
                    n_in.key_y      = i_key_y;
                    n_in.measure    = i_measure_in;
                    n_res_found     = 1'b0;
                    n_res           = '0;
                    n_res_status    = spkt_pkg::STATUS_OK;
                    n_scan_cnt      = '0;
                    case (i_mode)
                        spkt_pkg::MODE_INS_KEEP, spkt_pkg::MODE_INS_UPD,
                        spkt_pkg::MODE_LOOKUP, spkt_pkg::MODE_REMOVE: begin
                            n_state = S_CMP;
                        end
                        spkt_pkg::MODE_FIND_MAX, spkt_pkg::MODE_FIND_MIN: begin
                            if (r_count == '0) begin
                                n_res_status = spkt_pkg::STATUS_EMPTY;
                                n_state      = S_DONE;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_CMP: begin
                n_state = S_SEL;
            end
            S_SEL: begin
                n_hit   = |eq_v;
                n_sel   = sel_comb;
                n_state = S_APPLY;
            end
            S_APPLY: begin
                n_res_found = r_hit;
                case (r_mode)
                    spkt_pkg::MODE_INS_KEEP, spkt_pkg::MODE_INS_UPD: begin
                        if (r_hit) begin
                            n_res = r_sel;
                            if (r_mode == spkt_pkg::MODE_INS_UPD) begin
                                n_res.measure = r_in.measure;
                            end
                        end else if (full) begin
                            n_res_status = spkt_pkg::STATUS_FULL;
                        end else begin
                            n_res   = r_in;
                            n_count = r_count + CW'(1);
                        end
                    end
                    spkt_pkg::MODE_LOOKUP: begin
                        if (r_hit) begin
                            n_res = r_sel;
                        end
                    end
                    spkt_pkg::MODE_REMOVE: begin
                        if (r_hit) begin
                            n_res   = r_sel;
                            n_count = r_count - CW'(1);
                        end
                    end
                    default: begin
                    end
                endcase
                n_state = S_DONE;
            end
            S_SCAN: begin
                // advance one entry per cycle; after held_count steps the table is back in place
                n_scan_cnt = r_scan_cnt + CW'(1);
                if (scan_last) begin
                    n_res_found = 1'b1;
                    n_res       = scan_best;
                    n_state     = S_DONE;
                end
            end
            S_DONE: begin
                // hold the result until the output register is free
                if (!r_out_valid || !i_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_found  = r_res_found;
                    n_out        = r_res;
                    n_out_count  = r_count;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_mode       <= n_mode;
        r_in         <= n_in;
        r_hit        <= n_hit;
        r_sel        <= n_sel;
        r_scan_cnt   <= n_scan_cnt;
        r_res_found  <= n_res_found;
        r_res        <= n_res;
        r_res_status <= n_res_status;
        r_out_found  <= n_out_found;
        r_out        <= n_out;
        r_out_count  <= n_out_count;
        r_out_status <= n_out_status;
    end

    assign o_valid       = r_out_valid;
    assign o_found       = r_out_found;
    assign o_key_x_out   = r_out.key_x;
    assign o_key_y_out   = r_out.key_y;
    assign o_measure_out = r_out.measure;
    assign o_entry_count = r_out_count;
    assign o_status      = r_out_status;

endmodule
